// File: design/rcp_pkg.sv
// ============================================================================
// Ray cylinder path length: shared package
// Constants, configuration register codes and flag positions for the block.
// ============================================================================
package rcp_pkg;

  // Result width and the extra fraction bits carried through both roots.
  localparam int OUT_W      = 32;
  localparam int GUARD_BITS = 16;

  // Operand slice width of the pipelined wide multiplier.
  localparam int MUL_PIECE  = 33;

  // Defaults for the top level parameters.
  localparam int DEF_COORD_WIDTH = 32;
  localparam int DEF_FRAC_BITS   = 16;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_X   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CYL_RADIUS = 2'd2;

  // Result flag positions in the output tuser word.
  localparam int FLAG_W    = 3;
  localparam int FLAG_HIT  = 0;
  localparam int FLAG_AXIS = 1;
  localparam int FLAG_SAT  = 2;

endpackage

// File: design/rcp_mul_split.sv
// ============================================================================
// Ray cylinder path length: pipelined wide multiplier
// Unsigned product cut into slice products in the first stage, summed in the
// second stage. Takes one operand pair per cycle while en is high.
// ============================================================================
module rcp_mul_split #(
  parameter int AW = 64,
  parameter int BW = 64
) (
  input  logic             clk,
  input  logic             en,
  input  logic [AW-1:0]    a_i,
  input  logic [BW-1:0]    b_i,
  output logic [AW+BW-1:0] p_o
);

  localparam int PC = rcp_pkg::MUL_PIECE;
  localparam int NA = (AW + PC - 1) / PC;
  localparam int NB = (BW + PC - 1) / PC;
  localparam int PW = AW + BW;

  logic [NA*PC-1:0] a_pad;
  logic [NB*PC-1:0] b_pad;
  logic [2*PC-1:0]  part_r [NA*NB];
  logic [PW-1:0]    sum_nxt;
  logic [PW-1:0]    prod_r;

  assign a_pad = (NA*PC)'(a_i);
  assign b_pad = (NB*PC)'(b_i);

  // First stage: one registered product per slice pair.
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < NA; i++) begin
        for (int j = 0; j < NB; j++) begin
          part_r[i*NB+j] <= a_pad[i*PC +: PC] * b_pad[j*PC +: PC];
        end
      end
    end
  end

  // Second stage: weighted sum of the slice products.
  always_comb begin
    sum_nxt = '0;
    for (int i = 0; i < NA; i++) begin
      for (int j = 0; j < NB; j++) begin
        sum_nxt = sum_nxt + (PW'(part_r[i*NB+j]) << ((i + j) * PC));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= sum_nxt;
    end
  end

  assign p_o = prod_r;

endmodule

// File: design/rcp_sqrt_cell.sv
// ============================================================================
// Ray cylinder path length: square root cell
// One digit step of the integer square root: takes two radicand bits and
// settles one root bit, then hands its state to the next cell.
// ============================================================================
module rcp_sqrt_cell #(
  parameter int RW = 158,
  parameter int K  = 79
) (
  input  logic          clk,
  input  logic          en,
  input  logic [RW-1:0] rad_i,
  input  logic [K+1:0]  rem_i,
  input  logic [K-1:0]  root_i,
  output logic [RW-1:0] rad_o,
  output logic [K+1:0]  rem_o,
  output logic [K-1:0]  root_o
);

  logic [K+3:0]  trem;
  logic [K+3:0]  trial;
  logic [K+3:0]  diff;
  logic          ge;
  logic [RW-1:0] rad_r;
  logic [K+1:0]  rem_r;
  logic [K-1:0]  root_r;

  // Bring down two bits and try the next root bit.
  assign trem  = {rem_i, rad_i[RW-1:RW-2]};
  assign trial = {2'b00, root_i, 2'b01};
  assign diff  = trem - trial;
  assign ge    = trem >= trial;

  always_ff @(posedge clk) begin
    if (en) begin
      rad_r  <= {rad_i[RW-3:0], 2'b00};
      rem_r  <= ge ? diff[K+1:0] : trem[K+1:0];
      root_r <= {root_i[K-2:0], ge};
    end
  end

  assign rad_o  = rad_r;
  assign rem_o  = rem_r;
  assign root_o = root_r;

endmodule

// File: design/rcp_div_cell.sv
// ============================================================================
// Ray cylinder path length: division cell
// One restoring division step: shifts in one dividend bit, subtracts the
// divisor when it fits and appends one quotient bit.
// ============================================================================
module rcp_div_cell #(
  parameter int DW = 64,
  parameter int QW = 32
) (
  input  logic          clk,
  input  logic          en,
  input  logic [DW-1:0] den_i,
  input  logic [DW-1:0] rem_i,
  input  logic [QW-1:0] low_i,
  input  logic [QW-1:0] q_i,
  output logic [DW-1:0] den_o,
  output logic [DW-1:0] rem_o,
  output logic [QW-1:0] low_o,
  output logic [QW-1:0] q_o
);

  logic [DW:0]   trem;
  logic [DW:0]   diff;
  logic          ge;
  logic [DW-1:0] den_r;
  logic [DW-1:0] rem_r;
  logic [QW-1:0] low_r;
  logic [QW-1:0] q_r;

  // Trial subtraction of the divisor from the extended remainder.
  assign trem = {rem_i, low_i[QW-1]};
  assign diff = trem - {1'b0, den_i};
  assign ge   = trem >= {1'b0, den_i};

  always_ff @(posedge clk) begin
    if (en) begin
      den_r <= den_i;
      rem_r <= ge ? diff[DW-1:0] : trem[DW-1:0];
      low_r <= {low_i[QW-2:0], 1'b0};
      q_r   <= {q_i[QW-2:0], ge};
    end
  end

  assign den_o = den_r;
  assign rem_o = rem_r;
  assign low_o = low_r;
  assign q_o   = q_r;

endmodule

// File: design/ray_cylinder_path_length_unit.sv
// ============================================================================
// Ray cylinder path length unit
// Path length of a ray through an infinite z-parallel cylinder, fixed point.
// ============================================================================
//
//  channel  direction  word
//  -------  ---------  ---------------------------------------------------
//  in_      slave      one ray: origin x/y, direction x/y/z
//  out_     master     path length, flags hit / axis_parallel / saturated
//  cfg_     write      center_x (0), center_y (1), cyl_radius (2)
//
//  One word enters per cycle while no result waits in the skid register.
//  The two square root chains have K = 2*COORD_WIDTH - 1 + 16 cells each,
//  and the division chain has 32 cells.
//  Reset clears the valid bits and loads the register defaults.
//  When a result waits and out_tready is low the word moves into a skid
//  register; from the next cycle the whole pipeline holds and in_tready
//  stays low until that word has left.
//
module ray_cylinder_path_length_unit #(
  parameter int COORD_WIDTH = rcp_pkg::DEF_COORD_WIDTH,
  parameter int FRAC_BITS   = rcp_pkg::DEF_FRAC_BITS
) (
  input  logic clk,
  input  logic rst_n,
  // fields from bit 0: origin_x, origin_y, dir_x, dir_y, dir_z
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  input  logic [((5*COORD_WIDTH+7)/8)*8-1:0]    in_tdata,
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  // fields from bit 0: path_length
  output logic [((rcp_pkg::OUT_W+7)/8)*8-1:0]   out_tdata,
  // fields from bit 0: hit, axis_parallel, saturated
  output logic [rcp_pkg::FLAG_W-1:0]            out_tuser,
  input  logic                                  cfg_we,
  input  logic [rcp_pkg::CFG_IDX_W-1:0]         cfg_idx,
  input  logic [COORD_WIDTH-1:0]                cfg_wdata
);

  localparam int W     = COORD_WIDTH;
  localparam int G     = rcp_pkg::GUARD_BITS;
  localparam int QW    = rcp_pkg::OUT_W;
  localparam int ODW   = ((QW + 7) / 8) * 8;
  localparam int PXW   = W + 1;
  localparam int AW    = 2 * W;
  localparam int HW    = 2 * W + 2;
  localparam int CW    = 2 * W + 3;
  localparam int HMW   = 2 * W + 1;
  localparam int CMW   = 2 * W + 2;
  localparam int HHW   = 2 * HMW;
  localparam int ACW   = AW + CMW;
  localparam int EW    = 4 * W + 4;
  localparam int RW    = 4 * W - 2 + 2 * G;
  localparam int K     = RW / 2;
  localparam int LRW   = 2 * W + 1;
  localparam int LW    = W + G + 1;
  localparam int NW    = 2 * W + G + 1;
  localparam int NSW   = NW + 2;
  localparam int PRW   = LW + NW;
  localparam int DEPTH = 11 + K + QW;

  typedef struct packed {
    logic [AW-1:0]        a;
    logic signed [HW-1:0] h;
    logic                 cneg;
    logic [LRW-1:0]       lrad;
    logic                 axis;
  } mul_side_t;

  typedef struct packed {
    logic [AW-1:0]        a;
    logic signed [HW-1:0] h;
    logic                 cneg;
    logic                 axis;
    logic                 miss;
  } sq_side_t;

  typedef struct packed {
    logic [AW-1:0] a;
    logic          axis;
    logic          miss;
  } len_side_t;

  typedef struct packed {
    logic axis;
    logic miss;
    logic ovf;
  } div_flag_t;

  // --------------------------------------------------------------------------
  // Configuration registers and pipeline advance
  // --------------------------------------------------------------------------
  logic signed [W-1:0] cx_r;
  logic signed [W-1:0] cy_r;
  logic [W-2:0]        rad_r;
  logic [DEPTH-1:0]    vld_r;
  logic                adv;
  logic                skid_vld_r;

  // Register writes; indexes beyond the list are dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cx_r  <= '0;
      cy_r  <= '0;
      rad_r <= (W-1)'(1) << FRAC_BITS;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        rcp_pkg::REG_CENTER_X:   cx_r  <= cfg_wdata;
        rcp_pkg::REG_CENTER_Y:   cy_r  <= cfg_wdata;
        rcp_pkg::REG_CYL_RADIUS: rad_r <= cfg_wdata[W-2:0];
        default: ;
      endcase
    end
  end

  // The whole pipe moves unless the skid register holds a word.
  assign adv       = !skid_vld_r;
  assign in_tready = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[DEPTH-2:0], in_tvalid};
    end
  end

  // --------------------------------------------------------------------------
  // Stage 1: offsets from the axis
  // --------------------------------------------------------------------------
  logic signed [W-1:0]   in_ox, in_oy;
  logic signed [PXW-1:0] s1_px_r, s1_py_r;
  logic signed [W-1:0]   s1_dx_r, s1_dy_r, s1_dz_r;
  logic [W-2:0]          s1_rad_r;

  assign in_ox = in_tdata[0*W +: W];
  assign in_oy = in_tdata[1*W +: W];

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_px_r  <= {in_ox[W-1], in_ox} - {cx_r[W-1], cx_r};
      s1_py_r  <= {in_oy[W-1], in_oy} - {cy_r[W-1], cy_r};
      s1_dx_r  <= in_tdata[2*W +: W];
      s1_dy_r  <= in_tdata[3*W +: W];
      s1_dz_r  <= in_tdata[4*W +: W];
      s1_rad_r <= rad_r;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: single word products
  // --------------------------------------------------------------------------
  logic signed [2*W-1:0] s2_dxx_r, s2_dyy_r, s2_dzz_r;
  logic signed [2*W:0]   s2_dxpx_r, s2_dypy_r;
  logic signed [2*W+1:0] s2_pxx_r, s2_pyy_r;
  logic [2*W-3:0]        s2_rr_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_dxx_r  <= s1_dx_r * s1_dx_r;
      s2_dyy_r  <= s1_dy_r * s1_dy_r;
      s2_dzz_r  <= s1_dz_r * s1_dz_r;
      s2_dxpx_r <= s1_dx_r * s1_px_r;
      s2_dypy_r <= s1_dy_r * s1_py_r;
      s2_pxx_r  <= s1_px_r * s1_px_r;
      s2_pyy_r  <= s1_py_r * s1_py_r;
      s2_rr_r   <= s1_rad_r * s1_rad_r;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 3: quadratic coefficients a, h, c and the squared ray length
  // --------------------------------------------------------------------------
  logic [AW-1:0]        a_nxt;
  logic signed [CW-1:0] rr_s;
  mul_side_t            s3_side_r;
  logic signed [CW-1:0] s3_c_r;

  assign a_nxt = $unsigned(s2_dxx_r) + $unsigned(s2_dyy_r);
  assign rr_s  = $signed(CW'(s2_rr_r));

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_side_r.a    <= a_nxt;
      s3_side_r.h    <= HW'(s2_dxpx_r) + HW'(s2_dypy_r);
      s3_side_r.cneg <= 1'b0;
      s3_side_r.lrad <= LRW'(a_nxt) + LRW'($unsigned(s2_dzz_r));
      s3_side_r.axis <= (a_nxt == '0);
      s3_c_r         <= CW'(s2_pxx_r) + CW'(s2_pyy_r) - rr_s;
    end
  end

  // --------------------------------------------------------------------------
  // Stages 4-5: wide products h*h and a*|c|
  // --------------------------------------------------------------------------
  logic [HMW-1:0] hmag;
  logic [CMW-1:0] cmag;
  logic [HHW-1:0] hh;
  logic [ACW-1:0] ac;
  mul_side_t      mside_r [2];

  assign hmag = s3_side_r.h[HW-1] ? HMW'(-s3_side_r.h) : HMW'(s3_side_r.h);
  assign cmag = s3_c_r[CW-1] ? CMW'(-s3_c_r) : CMW'(s3_c_r);

  rcp_mul_split #(.AW(HMW), .BW(HMW)) u_mul_hh (
    .clk (clk),
    .en  (adv),
    .a_i (hmag),
    .b_i (hmag),
    .p_o (hh)
  );

  rcp_mul_split #(.AW(AW), .BW(CMW)) u_mul_ac (
    .clk (clk),
    .en  (adv),
    .a_i (s3_side_r.a),
    .b_i (cmag),
    .p_o (ac)
  );

  always_ff @(posedge clk) begin
    if (adv) begin
      mside_r[0] <= '{a: s3_side_r.a, h: s3_side_r.h, cneg: s3_c_r[CW-1],
                      lrad: s3_side_r.lrad, axis: s3_side_r.axis};
      mside_r[1] <= mside_r[0];
    end
  end

  // --------------------------------------------------------------------------
  // Stage 6: discriminant and square root radicands
  // --------------------------------------------------------------------------
  logic signed [EW-1:0] d_val;
  logic [RW-1:0]        s6_srad_r, s6_lrad_r;
  sq_side_t             s6_side_r;

  assign d_val = mside_r[1].cneg ? EW'(hh) + EW'(ac) : EW'(hh) - EW'(ac);

  always_ff @(posedge clk) begin
    if (adv) begin
      s6_srad_r      <= {d_val[4*W-3:0], (2*G)'(0)};
      s6_lrad_r      <= RW'({mside_r[1].lrad, (2*G)'(0)});
      s6_side_r.a    <= mside_r[1].a;
      s6_side_r.h    <= mside_r[1].h;
      s6_side_r.cneg <= mside_r[1].cneg;
      s6_side_r.axis <= mside_r[1].axis;
      s6_side_r.miss <= d_val[EW-1];
    end
  end

  // --------------------------------------------------------------------------
  // Square root cell chains: discriminant root and ray length side by side
  // --------------------------------------------------------------------------
  logic [RW-1:0] srad  [K+1];
  logic [K+1:0]  srem  [K+1];
  logic [K-1:0]  sroot [K+1];
  logic [RW-1:0] lrad  [K+1];
  logic [K+1:0]  lrem  [K+1];
  logic [K-1:0]  lroot [K+1];
  sq_side_t      sq_side_r [K];

  assign srad[0]  = s6_srad_r;
  assign srem[0]  = '0;
  assign sroot[0] = '0;
  assign lrad[0]  = s6_lrad_r;
  assign lrem[0]  = '0;
  assign lroot[0] = '0;

  for (genvar i = 0; i < K; i++) begin : g_sqrt
    rcp_sqrt_cell #(.RW(RW), .K(K)) u_s (
      .clk    (clk),
      .en     (adv),
      .rad_i  (srad[i]),
      .rem_i  (srem[i]),
      .root_i (sroot[i]),
      .rad_o  (srad[i+1]),
      .rem_o  (srem[i+1]),
      .root_o (sroot[i+1])
    );
    rcp_sqrt_cell #(.RW(RW), .K(K)) u_l (
      .clk    (clk),
      .en     (adv),
      .rad_i  (lrad[i]),
      .rem_i  (lrem[i]),
      .root_i (lroot[i]),
      .rad_o  (lrad[i+1]),
      .rem_o  (lrem[i+1]),
      .root_o (lroot[i+1])
    );
  end

  // Side data rides along the chain.
  always_ff @(posedge clk) begin
    if (adv) begin
      sq_side_r[0] <= s6_side_r;
      for (int i = 1; i < K; i++) begin
        sq_side_r[i] <= sq_side_r[i-1];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Numerator: far wall from inside, full chord from outside
  // --------------------------------------------------------------------------
  logic signed [HW+G-1:0] h_sh;
  logic signed [NSW-1:0]  n_diff;
  logic [NW-1:0]          n_nxt;
  logic [NW-1:0]          sn_n_r;
  logic [LW-1:0]          sn_lg_r;
  len_side_t              sn_side_r;
  len_side_t              m2_side_r [2];
  logic [PRW-1:0]         plen;

  assign h_sh   = {sq_side_r[K-1].h, G'(0)};
  assign n_diff = $signed(NSW'(sroot[K])) - NSW'(h_sh);

  always_comb begin
    if (sq_side_r[K-1].cneg) begin
      n_nxt = n_diff[NSW-1] ? '0 : n_diff[NW-1:0];
    end else begin
      n_nxt = NW'({sroot[K], 1'b0});
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sn_n_r         <= n_nxt;
      sn_lg_r        <= lroot[K][LW-1:0];
      sn_side_r.a    <= sq_side_r[K-1].a;
      sn_side_r.axis <= sq_side_r[K-1].axis;
      sn_side_r.miss <= sq_side_r[K-1].miss;
      m2_side_r[0]   <= sn_side_r;
      m2_side_r[1]   <= m2_side_r[0];
    end
  end

  // Ray length times numerator.
  rcp_mul_split #(.AW(LW), .BW(NW)) u_mul_len (
    .clk (clk),
    .en  (adv),
    .a_i (sn_lg_r),
    .b_i (sn_n_r),
    .p_o (plen)
  );

  // --------------------------------------------------------------------------
  // Overflow check and division setup
  // --------------------------------------------------------------------------
  logic [PRW-1:0] p_hi;
  logic [AW-1:0]  ov_den_r, ov_rem_r;
  logic [QW-1:0]  ov_low_r;
  div_flag_t      ov_flag_r;

  assign p_hi = plen >> (2 * G + QW);

  always_ff @(posedge clk) begin
    if (adv) begin
      ov_den_r       <= m2_side_r[1].a;
      ov_rem_r       <= p_hi[AW-1:0];
      ov_low_r       <= plen[2*G +: QW];
      ov_flag_r.axis <= m2_side_r[1].axis;
      ov_flag_r.miss <= m2_side_r[1].miss;
      ov_flag_r.ovf  <= p_hi >= PRW'(m2_side_r[1].a);
    end
  end

  // --------------------------------------------------------------------------
  // Division cell chain, one quotient bit per cell
  // --------------------------------------------------------------------------
  logic [AW-1:0] dden [QW+1];
  logic [AW-1:0] drem [QW+1];
  logic [QW-1:0] dlow [QW+1];
  logic [QW-1:0] dq   [QW+1];
  div_flag_t     dv_flag_r [QW];

  assign dden[0] = ov_den_r;
  assign drem[0] = ov_rem_r;
  assign dlow[0] = ov_low_r;
  assign dq[0]   = '0;

  for (genvar i = 0; i < QW; i++) begin : g_div
    rcp_div_cell #(.DW(AW), .QW(QW)) u_d (
      .clk   (clk),
      .en    (adv),
      .den_i (dden[i]),
      .rem_i (drem[i]),
      .low_i (dlow[i]),
      .q_i   (dq[i]),
      .den_o (dden[i+1]),
      .rem_o (drem[i+1]),
      .low_o (dlow[i+1]),
      .q_o   (dq[i+1])
    );
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dv_flag_r[0] <= ov_flag_r;
      for (int i = 1; i < QW; i++) begin
        dv_flag_r[i] <= dv_flag_r[i-1];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Output register
  // --------------------------------------------------------------------------
  div_flag_t     fl;
  logic          hit_nxt;
  logic [QW-1:0] out_len_r;
  logic          out_hit_r, out_axis_r, out_sat_r;

  assign fl      = dv_flag_r[QW-1];
  assign hit_nxt = !fl.axis && !fl.miss;

  always_ff @(posedge clk) begin
    if (adv) begin
      out_len_r  <= !hit_nxt ? '0 : (fl.ovf ? '1 : dq[QW]);
      out_hit_r  <= hit_nxt;
      out_axis_r <= fl.axis;
      out_sat_r  <= hit_nxt && fl.ovf;
    end
  end

  // --------------------------------------------------------------------------
  // Skid register: takes the last word when the output stalls
  // --------------------------------------------------------------------------
  logic [QW-1:0] skid_len_r;
  logic          skid_hit_r, skid_axis_r, skid_sat_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      skid_vld_r <= 1'b0;
    end else if (skid_vld_r) begin
      if (out_tready) begin
        skid_vld_r <= 1'b0;
      end
    end else if (vld_r[DEPTH-1] && !out_tready) begin
      skid_vld_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!skid_vld_r) begin
      skid_len_r  <= out_len_r;
      skid_hit_r  <= out_hit_r;
      skid_axis_r <= out_axis_r;
      skid_sat_r  <= out_sat_r;
    end
  end

  assign out_tvalid                    = skid_vld_r || vld_r[DEPTH-1];
  assign out_tdata                     = ODW'(skid_vld_r ? skid_len_r : out_len_r);
  assign out_tuser[rcp_pkg::FLAG_HIT]  = skid_vld_r ? skid_hit_r : out_hit_r;
  assign out_tuser[rcp_pkg::FLAG_AXIS] = skid_vld_r ? skid_axis_r : out_axis_r;
  assign out_tuser[rcp_pkg::FLAG_SAT]  = skid_vld_r ? skid_sat_r : out_sat_r;

`ifndef SYNTH
  // Clipping only happens on a hit.
  a_sat_hit: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[rcp_pkg::FLAG_SAT] |-> out_tuser[rcp_pkg::FLAG_HIT])
    else $error("saturated result without a hit");

  // A miss or an axis-parallel ray carries a zero length.
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[rcp_pkg::FLAG_HIT] |-> out_tdata == '0)
    else $error("nonzero length without a hit");

  // An axis-parallel ray never reports a hit.
  a_axis_nohit: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[rcp_pkg::FLAG_AXIS] |-> !out_tuser[rcp_pkg::FLAG_HIT])
    else $error("axis-parallel ray reported as hit");

  // With nothing waiting at the output the input is always open.
  a_ready_open: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input blocked while output is empty");
`endif

endmodule

// File: sim/ray_cylinder_path_length_checker.sv
// ============================================================================
// Ray cylinder path length: result checker
// Watches the configuration port and both stream channels. For every ray
// word taken in it computes the expected path length and flags at full
// integer precision, then compares each result word against the oldest
// expectation in order.
// ============================================================================
module ray_cylinder_path_length_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  input  logic                           in_tready,
  input  logic [159:0]                   in_tdata,
  input  logic                           out_tvalid,
  input  logic                           out_tready,
  input  logic [31:0]                    out_tdata,
  input  logic [rcp_pkg::FLAG_W-1:0]     out_tuser,
  input  logic                           cfg_we,
  input  logic [rcp_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [31:0]                    cfg_wdata,
  output int                             rays_in_flight,
  output int                             fail_count
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic signed [255:0] wide_t;

  typedef struct packed {
    logic [31:0] length;
    logic        hit;
    logic        axis;
    logic        sat;
  } path_result_t;

  // Cylinder geometry as the block currently holds it.
  logic [31:0] axis_x, axis_y;
  logic [30:0] radius;

  path_result_t expected_paths[$];

  // Integer square root, floor, digit by digit.
  function automatic wide_t root_floor(wide_t n);
    wide_t res, bitv, t;
    res = 0;
    bitv = wide_t'(1) <<< 254;
    while (bitv != 0) begin
      t = res + bitv;
      if (n >= t) begin
        n = n - t;
        res = (res >>> 1) + bitv;
      end else begin
        res = res >>> 1;
      end
      bitv = bitv >>> 2;
    end
    return res;
  endfunction

  // Chord or exit length of one ray through the current cylinder.
  function automatic path_result_t path_through_cylinder(logic [159:0] ray);
    wide_t ox, oy, dx, dy, dz, cx, cy, px, py, rr;
    wide_t a, h, c, disc, s, num, lg, q;
    path_result_t res;
    ox = $signed(ray[31:0]);
    oy = $signed(ray[63:32]);
    dx = $signed(ray[95:64]);
    dy = $signed(ray[127:96]);
    dz = $signed(ray[159:128]);
    cx = $signed(axis_x);
    cy = $signed(axis_y);
    rr = $signed({1'b0, radius});
    res = '0;
    px = ox - cx;
    py = oy - cy;
    a = dx * dx + dy * dy;
    if (a == 0) begin
      res.axis = 1'b1;
      return res;
    end
    h = dx * px + dy * py;
    c = px * px + py * py - rr * rr;
    disc = h * h - a * c;
    if (disc < 0) return res;
    s = root_floor(disc <<< (2 * rcp_pkg::GUARD_BITS));
    if (c < 0) begin
      // Origin inside: run from the origin to the far wall.
      num = s - (h <<< rcp_pkg::GUARD_BITS);
      if (num < 0) num = 0;
    end else begin
      num = s <<< 1;
    end
    lg = root_floor((a + dz * dz) <<< (2 * rcp_pkg::GUARD_BITS));
    q = (lg * num) / (a <<< (2 * rcp_pkg::GUARD_BITS));
    res.hit = 1'b1;
    if (q[255:32] != 0) begin
      res.sat = 1'b1;
      res.length = '1;
    end else begin
      res.length = q[31:0];
    end
    return res;
  endfunction

  assign rays_in_flight = expected_paths.size();

  // Track registers, queue expectations and compare result words.
  always_ff @(posedge clk) begin
    path_result_t want, got;
    if (!rst_n) begin
      axis_x <= '0;
      axis_y <= '0;
      radius <= 31'd65536;
      fail_count <= 0;
      expected_paths.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_idx)
          rcp_pkg::REG_CENTER_X:   axis_x <= cfg_wdata;
          rcp_pkg::REG_CENTER_Y:   axis_y <= cfg_wdata;
          rcp_pkg::REG_CYL_RADIUS: radius <= cfg_wdata[30:0];
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) expected_paths.push_back(path_through_cylinder(in_tdata));
      if (out_tvalid && out_tready) begin
        got.length = out_tdata;
        got.hit = out_tuser[rcp_pkg::FLAG_HIT];
        got.axis = out_tuser[rcp_pkg::FLAG_AXIS];
        got.sat = out_tuser[rcp_pkg::FLAG_SAT];
        if (expected_paths.size() == 0) begin
          if (fail_count < 10) $display("unexpected result word: length %h flags %b",
                                        out_tdata, out_tuser);
          fail_count <= fail_count + 1;
        end else begin
          want = expected_paths.pop_front();
          if (want != got) begin
            if (fail_count < 10)
              $display("mismatch: expected length %h hit %b axis %b sat %b, got %h %b %b %b",
                       want.length, want.hit, want.axis, want.sat,
                       got.length, got.hit, got.axis, got.sat);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end
endmodule

// File: sim/ray_cylinder_path_length_unit_tb.sv
// ============================================================================
// Ray cylinder path length unit: testbench
// Sends directed and random rays through several cylinder settings, with
// random gaps and stalls on both channels, and gives the verdict from the
// failure count of the checker and the rays it still holds in flight.
// ============================================================================
module ray_cylinder_path_length_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [rcp_pkg::CFG_IDX_W-1:0] REG_SPARE = 2'd3;
  localparam int DRAIN_CYCLES = 200;
  localparam int CYCLE_LIMIT = 1000000;
  localparam logic [31:0] ONE = 32'h0001_0000;
  localparam logic [31:0] MAX_POS = 32'h7FFF_FFFF;
  localparam logic [31:0] MAX_NEG = 32'h8000_0000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [159:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [31:0] out_tdata;
  logic [rcp_pkg::FLAG_W-1:0] out_tuser;
  logic cfg_we = 1'b0;
  logic [rcp_pkg::CFG_IDX_W-1:0] cfg_idx = '0;
  logic [31:0] cfg_wdata = '0;
  logic word_taken = 1'b0;
  int rays_in_flight, fail_count, cycles = 0;
  bit hold_receiver = 1'b0;
  bit steady_flow = 1'b0;
  logic [31:0] cur_cx = '0, cur_cy = '0;

  always #5 clk = ~clk;

  ray_cylinder_path_length_unit DUT (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_wdata(cfg_wdata)
  );

  ray_cylinder_path_length_checker checker_i (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_wdata(cfg_wdata),
    .rays_in_flight(rays_in_flight), .fail_count(fail_count)
  );

  // Acceptance as seen at the last rising edge, read at the falling edge.
  always @(posedge clk) word_taken <= in_tvalid && in_tready;

  // Watchdog.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("ray_cylinder_path_length_unit_tb failed");
      $finish;
    end
  end

  // Mostly short gaps, now and then a long one.
  function automatic int gap_length();
    if ($urandom_range(0, 9) < 6) return 0;
    if ($urandom_range(0, 24) == 0) return $urandom_range(20, 80);
    return $urandom_range(1, 4);
  endfunction

  // Receiver: random back-pressure, or one long hold-off on request.
  always begin
    int stall;
    @(negedge clk);
    if (hold_receiver) begin
      out_tready <= 1'b0;
      repeat (400) @(negedge clk);
      hold_receiver = 1'b0;
    end else begin
      stall = steady_flow ? 0 : gap_length();
      out_tready <= (stall == 0);
      repeat (stall) @(negedge clk);
    end
  end

  // Offer one ray word and hold it until taken, then maybe idle.
  task automatic send_ray(logic [31:0] ox, logic [31:0] oy, logic [31:0] dx,
                          logic [31:0] dy, logic [31:0] dz);
    int gap;
    in_tvalid <= 1'b1;
    in_tdata <= {dz, dy, dx, oy, ox};
    do @(negedge clk); while (!word_taken);
    gap = (steady_flow || hold_receiver) ? 0 : gap_length();
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  // Wait until every result is back, then let the pipeline empty.
  task automatic drain();
    in_tvalid <= 1'b0;
    @(negedge clk);
    while (rays_in_flight != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // Load a new cylinder while the block is idle.
  task automatic set_cylinder(logic [31:0] cx, logic [31:0] cy, logic [31:0] r);
    cfg_we <= 1'b1;
    cfg_idx <= rcp_pkg::REG_CENTER_X;
    cfg_wdata <= cx;
    @(negedge clk);
    cfg_idx <= rcp_pkg::REG_CENTER_Y;
    cfg_wdata <= cy;
    @(negedge clk);
    cfg_idx <= rcp_pkg::REG_CYL_RADIUS;
    cfg_wdata <= r;
    @(negedge clk);
    cfg_idx <= REG_SPARE;
    cfg_wdata <= $urandom;
    @(negedge clk);
    cfg_we <= 1'b0;
    cur_cx = cx;
    cur_cy = cy;
  endtask

  // Random direction component at a random magnitude.
  function automatic logic [31:0] scaled_value(int shift);
    return $signed($urandom) >>> shift;
  endfunction

  // A ray that starts near the axis, or pure noise.
  task automatic random_ray();
    int sp, sd;
    logic [31:0] dz;
    if ($urandom_range(0, 9) < 7) begin
      sp = $urandom_range(1, 31);
      sd = $urandom_range(0, 31);
      dz = ($urandom_range(0, 3) == 0) ? 32'd0 : scaled_value($urandom_range(0, 31));
      if ($urandom_range(0, 19) == 0)
        send_ray(cur_cx + scaled_value(sp), cur_cy + scaled_value(sp), 32'd0, 32'd0, dz);
      else
        send_ray(cur_cx + scaled_value(sp), cur_cy + scaled_value(sp),
                 scaled_value(sd), scaled_value(sd), dz);
    end else begin
      send_ray($urandom, $urandom, $urandom, $urandom, $urandom);
    end
  endtask

  initial begin
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed rays against the reset cylinder of radius one at the origin.
    send_ray(0, 0, 0, 0, ONE);                       // parallel to the axis
    send_ray(MAX_POS, MAX_NEG, 0, 0, MAX_NEG);       // parallel, far away
    send_ray(0, 0, ONE, 0, 0);                       // inside, along x
    send_ray(ONE >> 1, 0, ONE, ONE, ONE);            // inside, slanted
    send_ray(-2 * ONE, 0, ONE, 0, 0);                // outside, full chord
    send_ray(-2 * ONE, 0, -ONE, 0, ONE);             // outside, pointing away
    send_ray(-2 * ONE, 2 * ONE, ONE, 0, 0);          // miss
    send_ray(-ONE, 0, ONE, 0, 0);                    // on the surface
    send_ray(-2 * ONE, ONE, ONE, 0, 0);              // tangent
    send_ray(MAX_POS, MAX_POS, MAX_POS, MAX_POS, MAX_POS);
    send_ray(MAX_NEG, MAX_NEG, MAX_NEG, MAX_NEG, MAX_NEG);
    send_ray(MAX_NEG, MAX_POS, MAX_POS, MAX_NEG, 0);
    send_ray(0, 0, 32'd1, 0, MAX_NEG);               // tiniest direction
    send_ray(0, 0, 0, 32'hFFFF_FFFF, MAX_POS);
    send_ray(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    drain();

    // Widest cylinder: long chords saturate the result.
    set_cylinder(MAX_NEG, MAX_POS, 32'hFFFF_FFFF);
    send_ray(MAX_NEG, MAX_POS, ONE, 0, 0);
    send_ray(0, 0, ONE, ONE, MAX_POS);
    send_ray(MAX_POS, MAX_NEG, ONE, 32'd1, 0);
    send_ray(MAX_NEG, MAX_POS, 32'd1, 0, MAX_POS);

    // Random phases across several cylinders, extremes included.
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: ;
        1: set_cylinder(0, 0, 32'd0);
        2: set_cylinder(MAX_POS, MAX_NEG, ONE);
        3: set_cylinder($urandom, $urandom, $urandom_range(1, 32'h0100_0000));
        default: set_cylinder($urandom, $urandom, $urandom);
      endcase
      steady_flow = (phase == 4);
      for (int k = 0; k < 230; k++) begin
        if (phase == 1 && k == 50) hold_receiver = 1'b1;
        random_ray();
      end
      drain();
    end

    if (fail_count == 0 && rays_in_flight == 0) begin
      $display("ray_cylinder_path_length_unit_tb passed");
    end else begin
      $display("ray_cylinder_path_length_unit_tb failed");
    end
    $finish;
  end
endmodule

// File: filelist.f
design/rcp_pkg.sv
design/rcp_mul_split.sv
design/rcp_sqrt_cell.sv
design/rcp_div_cell.sv
design/ray_cylinder_path_length_unit.sv
sim/ray_cylinder_path_length_checker.sv
sim/ray_cylinder_path_length_unit_tb.sv
